// File: hdl/mqps_pkg.sv
package mqps_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int HANDLE_W  = 16;
    localparam int MS_W      = 16;
    localparam int TIMER_W   = 17;
    localparam int QUEUED_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W      = 56;
    localparam int OUT_W     = 64;
    localparam int IN_USED   = HANDLE_W + 1 + MS_W + MS_W;
    localparam int OUT_USED  = 1 + 1 + 2 + HANDLE_W + 1 + TIMER_W + TIMER_W + QUEUED_W;

    // Command codes carried on s_tuser
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLIDE_IN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_HOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLIDE_OUT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP     = 2'd3;

    // Configuration reset values
    localparam logic [MS_W-1:0] RST_SLIDE_IN     = 16'd250;
    localparam logic [MS_W-1:0] RST_DEFAULT_HOLD = 16'd2000;
    localparam logic [MS_W-1:0] RST_SLIDE_OUT    = 16'd250;
    localparam logic [MS_W-1:0] RST_MAX_STEP     = 16'd250;

    // Display phases
    typedef enum logic [1:0] {
        PH_IN   = 2'd0,
        PH_HOLD = 2'd1,
        PH_OUT  = 2'd2
    } phase_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Saturating timer add
    function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                   input logic [MS_W-1:0] b);
        logic [TIMER_W:0] s;
        s = {1'b0, a} + {2'b00, b};
        return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
    endfunction

endpackage

// File: hdl/message_queue_phase_sequencer.sv
// Channel   Direction  Payload
// s_        in         tuser: command[1:0]
//                      tdata: message_handle, with_icon, hold_request_ms, elapsed_ms
// m_        out        tdata: accepted, showing, phase, current_handle, current_icon,
//                             phase_elapsed_ms, hold_elapsed_ms, queued
// cfg_      in         cfg_index selects slide_in, default_hold, slide_out, max_step
//
// Each transaction is first captured, then used to update the queue and sequencer and
// load the output register; a new transaction is taken only once the last one is done.
// The update cycle waits while the output register still holds a result not yet taken.
// aresetn is synchronous; control state and configuration return to their reset values
// at once, and no clearing pass runs over the queue slots.
module message_queue_phase_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [mqps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mqps_pkg::MS_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // message_handle[15:0], with_icon[16], hold_request_ms[32:17], elapsed_ms[48:33]
    input  logic [mqps_pkg::IN_W-1:0]      s_tdata,
    // command[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // accepted[0], showing[1], phase[3:2], current_handle[19:4], current_icon[20],
    // phase_elapsed_ms[37:21], hold_elapsed_ms[54:38], queued[58:55]
    output logic [mqps_pkg::OUT_W-1:0]     m_tdata
);

    mqps_pkg::dp_cmd_t    cmd;
    mqps_pkg::dp_status_t status;

    mqps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mqps_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: hdl/mqps_ctrl.sv
module mqps_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mqps_pkg::dp_status_t status,
    output mqps_pkg::dp_cmd_t    cmd
);

    mqps_pkg::ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mqps_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture a transaction, then commit it once the output register is free
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            mqps_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = mqps_pkg::ST_EXEC;
                end
            end
            mqps_pkg::ST_EXEC: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = mqps_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

// File: hdl/mqps_datapath.sv
module mqps_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [mqps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mqps_pkg::MS_W-1:0]            cfg_data,
    input  logic [mqps_pkg::IN_W-1:0]            s_tdata,
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mqps_pkg::OUT_W-1:0]           m_tdata,
    input  mqps_pkg::dp_cmd_t                    cmd,
    output mqps_pkg::dp_status_t                 status
);

    localparam int PW = mqps_pkg::PTR_W;
    localparam int CW = mqps_pkg::CNT_W;
    localparam int HW = mqps_pkg::HANDLE_W;
    localparam int MW = mqps_pkg::MS_W;
    localparam int TW = mqps_pkg::TIMER_W;

    // Configuration
    logic [MW-1:0] slide_in_reg, default_hold_reg, slide_out_reg, max_step_reg;

    // Captured transaction
    logic [1:0]    command_reg;
    logic [HW-1:0] handle_in_reg;
    logic          icon_in_reg;
    logic [MW-1:0] hold_in_reg;
    logic [MW-1:0] elapsed_reg;

    // Queue storage
    logic [HW-1:0] q_handle_reg [mqps_pkg::QUEUE_DEPTH];
    logic          q_icon_reg   [mqps_pkg::QUEUE_DEPTH];
    logic [MW-1:0] q_hold_reg   [mqps_pkg::QUEUE_DEPTH];

    // Sequencer state
    logic [PW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 active_reg, active_next;
    mqps_pkg::phase_t     phase_reg, phase_next;
    logic [TW-1:0]        ptimer_reg, ptimer_next;
    logic [TW-1:0]        htimer_reg, htimer_next;
    logic [MW-1:0]        target_reg, target_next;
    logic [HW-1:0]        shown_handle_reg, shown_handle_next;
    logic                 shown_icon_reg, shown_icon_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [mqps_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    // Working signals
    logic [MW-1:0] dt;
    logic [TW-1:0] pt_sum, ht_sum;
    logic [MW-1:0] hold_lim;
    logic [CW:0]   slot_sum;
    logic [CW:0]   slot_wrap;
    logic [PW-1:0] wr_slot;
    logic [PW-1:0] head_inc;
    logic          q_we;
    logic          do_start;
    logic          accepted;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slide_in_reg     <= mqps_pkg::RST_SLIDE_IN;
            default_hold_reg <= mqps_pkg::RST_DEFAULT_HOLD;
            slide_out_reg    <= mqps_pkg::RST_SLIDE_OUT;
            max_step_reg     <= mqps_pkg::RST_MAX_STEP;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mqps_pkg::REG_SLIDE_IN:     slide_in_reg     <= cfg_data;
                mqps_pkg::REG_DEFAULT_HOLD: default_hold_reg <= cfg_data;
                mqps_pkg::REG_SLIDE_OUT:    slide_out_reg    <= cfg_data;
                mqps_pkg::REG_MAX_STEP:     max_step_reg     <= cfg_data;
            endcase
        end
    end

    // Capture the input transaction
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            command_reg   <= s_tuser;
            handle_in_reg <= s_tdata[HW-1:0];
            icon_in_reg   <= s_tdata[HW];
            hold_in_reg   <= s_tdata[HW+MW:HW+1];
            elapsed_reg   <= s_tdata[HW+2*MW:HW+MW+1];
        end
    end

    // Queue slot write
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_handle_reg[wr_slot] <= handle_in_reg;
            q_icon_reg[wr_slot]   <= icon_in_reg;
            q_hold_reg[wr_slot]   <= hold_in_reg;
        end
    end

    // Sequencer and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg         <= '0;
            count_reg        <= '0;
            active_reg       <= 1'b0;
            phase_reg        <= mqps_pkg::PH_IN;
            ptimer_reg       <= '0;
            htimer_reg       <= '0;
            target_reg       <= '0;
            shown_handle_reg <= '0;
            shown_icon_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            head_reg         <= head_next;
            count_reg        <= count_next;
            active_reg       <= active_next;
            phase_reg        <= phase_next;
            ptimer_reg       <= ptimer_next;
            htimer_reg       <= htimer_next;
            target_reg       <= target_next;
            shown_handle_reg <= shown_handle_next;
            shown_icon_reg   <= shown_icon_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data_reg <= out_data_next;
        end
    end

    // Limit the step and advance the timers
    assign dt       = (elapsed_reg > max_step_reg) ? max_step_reg : elapsed_reg;
    assign pt_sum   = mqps_pkg::sat_add(ptimer_reg, dt);
    assign ht_sum   = mqps_pkg::sat_add(htimer_reg, dt);
    assign hold_lim = (target_reg == '0) ? default_hold_reg : target_reg;

    // Tail slot and head advance, wrapped at the queue depth
    assign slot_sum  = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign slot_wrap = (slot_sum >= (CW+1)'(mqps_pkg::QUEUE_DEPTH))
                     ? slot_sum - (CW+1)'(mqps_pkg::QUEUE_DEPTH) : slot_sum;
    assign wr_slot   = slot_wrap[PW-1:0];
    assign head_inc  = (head_reg == PW'(mqps_pkg::QUEUE_DEPTH - 1))
                     ? '0 : head_reg + PW'(1);

    // Apply the command
    always_comb begin
        head_next         = head_reg;
        count_next        = count_reg;
        active_next       = active_reg;
        phase_next        = phase_reg;
        ptimer_next       = ptimer_reg;
        htimer_next       = htimer_reg;
        target_next       = target_reg;
        shown_handle_next = shown_handle_reg;
        shown_icon_next   = shown_icon_reg;
        q_we              = 1'b0;
        do_start          = 1'b0;
        accepted          = 1'b0;

        if (cmd.commit) begin
            case (command_reg)
                mqps_pkg::CMD_PUSH: begin
                    if (handle_in_reg != '0 && count_reg < CW'(mqps_pkg::QUEUE_DEPTH)) begin
                        q_we       = 1'b1;
                        count_next = count_reg + CW'(1);
                        accepted   = 1'b1;
                    end
                end
                mqps_pkg::CMD_TICK: begin
                    if (!active_reg) begin
                        // Idle: only start the next message
                        do_start = (count_reg != '0);
                    end else begin
                        ptimer_next = pt_sum;
                        unique case (phase_reg)
                            mqps_pkg::PH_IN: begin
                                if (pt_sum >= {1'b0, slide_in_reg}) begin
                                    phase_next  = mqps_pkg::PH_HOLD;
                                    ptimer_next = '0;
                                    htimer_next = '0;
                                end
                            end
                            mqps_pkg::PH_HOLD: begin
                                htimer_next = ht_sum;
                                if (pt_sum >= {1'b0, hold_lim}) begin
                                    phase_next  = mqps_pkg::PH_OUT;
                                    ptimer_next = '0;
                                end
                            end
                            mqps_pkg::PH_OUT: begin
                                if (pt_sum >= {1'b0, slide_out_reg}) begin
                                    active_next       = 1'b0;
                                    shown_handle_next = '0;
                                    shown_icon_next   = 1'b0;
                                    target_next       = '0;
                                    phase_next        = mqps_pkg::PH_IN;
                                    ptimer_next       = '0;
                                    htimer_next       = '0;
                                    do_start          = (count_reg != '0);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                mqps_pkg::CMD_CLEAR: begin
                    head_next         = '0;
                    count_next        = '0;
                    active_next       = 1'b0;
                    phase_next        = mqps_pkg::PH_IN;
                    ptimer_next       = '0;
                    htimer_next       = '0;
                    target_next       = '0;
                    shown_handle_next = '0;
                    shown_icon_next   = 1'b0;
                end
                default: ;
            endcase

            // Pop the oldest entry onto the display
            if (do_start) begin
                shown_handle_next = q_handle_reg[head_reg];
                shown_icon_next   = q_icon_reg[head_reg];
                target_next       = q_hold_reg[head_reg];
                head_next         = head_inc;
                count_next        = count_reg - CW'(1);
                active_next       = 1'b1;
                phase_next        = mqps_pkg::PH_IN;
                ptimer_next       = '0;
                htimer_next       = '0;
            end
        end
    end

    // Result word and output handshake
    assign out_data_next = {{(mqps_pkg::OUT_W - mqps_pkg::OUT_USED){1'b0}},
                            mqps_pkg::QUEUED_W'(count_next),
                            htimer_next,
                            ptimer_next,
                            shown_icon_next,
                            shown_handle_next,
                            phase_next,
                            active_next,
                            accepted};

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

endmodule

// File: hdl/mqps_checker.sv
module mqps_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mqps_pkg::OUT_W-1:0]     m_tdata
);

    // One transaction in flight: input side closes after each capture
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous transaction still in work");

    // Stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // Idle display shows no handle, slide in phase and cleared timers
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[19:4] == 16'd0 && m_tdata[3:2] == 2'd0
            && m_tdata[54:21] == 34'd0)
        else $error("idle status carries display state");

    // Phase code and fill level stay in range
    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:2] != 2'd3
            && m_tdata[58:55] <= 4'(mqps_pkg::QUEUE_DEPTH))
        else $error("phase or queue level out of range");

endmodule

bind message_queue_phase_sequencer mqps_checker u_mqps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
